FILE: hdl/hbd_pkg.sv
package hbd_pkg;

  // Field widths of the node table and the stream
  localparam int IDX_W          = 9;
  localparam int LETTER_W       = 8;
  localparam int NODE_COUNT_DEF = 512;

  // Command codes carried in the command field
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  // One table entry
  typedef struct packed {
    logic [IDX_W-1:0]    left;
    logic [IDX_W-1:0]    right;
    logic                is_leaf;
    logic [LETTER_W-1:0] letter;
  } node_t;

  // Update of the walk position
  typedef enum logic [1:0] {
    WALK_HOLD,
    WALK_ZERO,
    WALK_CHILD
  } walk_op_t;

  // Controller to datapath
  typedef struct packed {
    logic     accept;
    logic     wr_en;
    logic     rd_en;
    logic     rd_child;
    walk_op_t walk_op;
    logic     emit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_valid;
    logic command;
    logic tree_loaded;
    logic is_leaf;
    logic last_bit;
    logic out_free;
  } ctrl_stat_t;

endpackage

FILE: hdl/hbd_if.sv
interface hbd_in_if;
  import hbd_pkg::*;

  logic                valid;
  logic                ready;
  logic                command;
  logic [IDX_W-1:0]    node_addr;
  logic [IDX_W-1:0]    left_child;
  logic [IDX_W-1:0]    right_child;
  logic                is_leaf;
  logic [LETTER_W-1:0] leaf_letter;
  logic                code_bit;
  logic                last_bit;

  modport source (
    output valid, command, node_addr, left_child, right_child,
           is_leaf, leaf_letter, code_bit, last_bit,
    input  ready
  );

  modport sink (
    input  valid, command, node_addr, left_child, right_child,
           is_leaf, leaf_letter, code_bit, last_bit,
    output ready
  );
endinterface

interface hbd_out_if;
  import hbd_pkg::*;

  logic                valid;
  logic                ready;
  logic [LETTER_W-1:0] letter;

  modport source (output valid, letter, input ready);
  modport sink (input valid, letter, output ready);
endinterface

FILE: hdl/hbd_ctrl.sv
module hbd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  hbd_pkg::ctrl_stat_t stat,
  output hbd_pkg::ctrl_cmd_t  cmd
);
  import hbd_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    LOOK_CUR,
    LOOK_CHILD
  } state_t;

  state_t state;
  state_t state_next;

  // Sequence one word: write, or up to two table lookups per decoded bit
  always_comb begin
    cmd        = '0;
    cmd.walk_op = WALK_HOLD;
    state_next = state;
    case (state)
      IDLE: begin
        cmd.accept = 1'b1;
        if (stat.in_valid) begin
          if (stat.command == CMD_WRITE) begin
            cmd.wr_en   = 1'b1;
            cmd.walk_op = WALK_ZERO;
          end else if (!stat.tree_loaded) begin
            cmd.walk_op = WALK_ZERO;
          end else begin
            cmd.rd_en  = 1'b1;
            state_next = LOOK_CUR;
          end
        end
      end
      LOOK_CUR: begin
        if (stat.is_leaf) begin
          if (stat.out_free) begin
            cmd.emit    = 1'b1;
            cmd.walk_op = WALK_ZERO;
            state_next  = IDLE;
          end
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.rd_child = 1'b1;
          state_next   = LOOK_CHILD;
        end
      end
      LOOK_CHILD: begin
        if (stat.is_leaf) begin
          if (stat.out_free) begin
            cmd.emit    = 1'b1;
            cmd.walk_op = WALK_ZERO;
            state_next  = IDLE;
          end
        end else begin
          cmd.walk_op = stat.last_bit ? WALK_ZERO : WALK_CHILD;
          state_next  = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: hdl/hbd_datapath.sv
module hbd_datapath #(
  parameter int NODE_COUNT = hbd_pkg::NODE_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  hbd_in_if.sink              in,
  hbd_out_if.source           out,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  hbd_pkg::ctrl_cmd_t  cmd,
  output hbd_pkg::ctrl_stat_t stat
);
  import hbd_pkg::*;

  localparam int AW    = $clog2(NODE_COUNT);
  localparam int EXT_W = IDX_W + 2;

  node_t mem [NODE_COUNT];

  logic                tree_loaded;
  logic [IDX_W-1:0]    walk;
  logic [IDX_W-1:0]    rd_addr;
  logic                rd_ok;
  node_t               rd_data;
  logic                code_bit;
  logic                last_bit;
  logic                out_valid;
  logic [LETTER_W-1:0] letter;

  node_t            entry;
  logic [IDX_W-1:0] child;
  logic [IDX_W-1:0] rd_addr_next;
  logic [EXT_W-1:0] rd_ext;
  logic [EXT_W-1:0] wr_ext;
  logic             rd_in_range;
  logic             wr_in_range;
  logic             out_free;

  // Entries beyond the table read as an all-zero inner node
  assign entry        = rd_ok ? rd_data : '0;
  assign child        = code_bit ? entry.right : entry.left;
  assign rd_addr_next = cmd.rd_child ? child : walk;
  assign rd_ext       = {2'b00, rd_addr_next};
  assign wr_ext       = {2'b00, in.node_addr};
  assign rd_in_range  = rd_ext < EXT_W'(NODE_COUNT);
  assign wr_in_range  = wr_ext < EXT_W'(NODE_COUNT);
  assign out_free     = !out_valid || out.ready;

  assign in.ready   = cmd.accept;
  assign out.valid  = out_valid;
  assign out.letter = letter;

  assign stat.in_valid    = in.valid;
  assign stat.command     = in.command;
  assign stat.tree_loaded = tree_loaded;
  assign stat.is_leaf     = entry.is_leaf;
  assign stat.last_bit    = last_bit;
  assign stat.out_free    = out_free;

  // Node table write port
  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_in_range) begin
      mem[wr_ext[AW-1:0]] <= '{left:    in.left_child,
                               right:   in.right_child,
                               is_leaf: in.is_leaf,
                               letter:  in.leaf_letter};
    end
  end

  // Node table read port, registered
  always_ff @(posedge clk) begin
    if (cmd.rd_en && rd_in_range) begin
      rd_data <= mem[rd_ext[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_addr <= rd_addr_next;
    end
    if (in.valid && cmd.accept) begin
      code_bit <= in.code_bit;
      last_bit <= in.last_bit;
    end
    if (cmd.emit) begin
      letter <= entry.letter;
    end
  end

  // Control registers: config, walk position, read valid, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      tree_loaded <= 1'b0;
      walk        <= '0;
      rd_ok       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        tree_loaded <= cfg_wdata;
      end
      case (cmd.walk_op)
        WALK_ZERO:  walk <= '0;
        WALK_CHILD: walk <= rd_addr;
        default:    walk <= walk;
      endcase
      if (cmd.rd_en) begin
        rd_ok <= rd_in_range;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/huffman_bit_decoder_core.sv
// Prefix-code stream decoder that walks a node table held in block memory.
// Channels: "in" takes words that either write one table node (command 0)
// or carry one code bit (command 1); "out" returns one decoded letter per
// leaf reached. cfg_we/cfg_wdata set tree_loaded; with it low, decode words
// produce nothing and only send the walk back to the root.
// A node write returns the walk to the root. A decode word looks up the
// current node and, when it must step to a child, that child as well; each
// table lookup goes through the registered read port, and at most two
// lookups are made per bit. A letter is written to the output register when
// a lookup finds a leaf. A new word is accepted once the previous one is
// done, while the letter still waits in the output register.
// If the receiver stalls and the output register is still full, a decode
// that reaches a leaf holds in place until the register frees up.
// Reset (rst, synchronous) clears tree_loaded, the walk position and the
// output valid; table contents stay undefined until written.
module huffman_bit_decoder_core #(
  parameter int NODE_COUNT = hbd_pkg::NODE_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  hbd_in_if.sink    in,
  hbd_out_if.source out,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);
  import hbd_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  hbd_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  hbd_datapath #(
    .NODE_COUNT (NODE_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in        (in),
    .out       (out),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

FILE: verif/walk_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the cfg_we/cfg_wdata inputs, keeps its own copy of the
// node table and walk position, and checks each letter word against the
// oldest predicted letter.
module walk_checker (
  input  logic clk,
  input  logic rst,
  hbd_in_if    in_ch,
  hbd_out_if   out_ch,
  input  logic cfg_we,
  input  logic cfg_wdata,
  output int   pending,
  output int   fail_count
);
  import hbd_pkg::*;

  node_t               nodes [NODE_COUNT_DEF];
  logic [IDX_W-1:0]    walk;
  logic                loaded;
  logic [LETTER_W-1:0] letters_due [$];

  // Advance the walk by one code bit and queue a letter when a leaf is hit
  function automatic void walk_one_bit(input logic code, input logic stop);
    node_t            entry;
    logic [IDX_W-1:0] pos;
    if (!loaded) begin
      walk = '0;
      return;
    end
    pos   = walk;
    entry = nodes[pos];
    if (!entry.is_leaf) begin
      pos   = code ? entry.right : entry.left;
      entry = nodes[pos];
    end
    if (entry.is_leaf) begin
      letters_due.insert(letters_due.size(), entry.letter);
      pos = '0;
    end
    if (stop) pos = '0;
    walk = pos;
  endfunction

  always @(posedge clk) begin : watch
    logic [LETTER_W-1:0] want;
    if (rst) begin
      walk       = '0;
      loaded     = 1'b0;
      fail_count = 0;
      letters_due.delete();
    end else begin
      // Compare a delivered letter word with the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (letters_due.size() == 0) begin
          $error("letter: expected nothing, actual %0h", out_ch.letter);
          fail_count++;
        end else begin
          want = letters_due.pop_front();
          if (out_ch.letter !== want) begin
            $error("letter: expected %0h, actual %0h", want, out_ch.letter);
            fail_count++;
          end
        end
      end

      if (cfg_we) loaded = cfg_wdata;

      // Apply an accepted input word to the table copy or the walk
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.command == CMD_WRITE) begin
          nodes[in_ch.node_addr] = '{left:    in_ch.left_child,
                                     right:   in_ch.right_child,
                                     is_leaf: in_ch.is_leaf,
                                     letter:  in_ch.leaf_letter};
          walk = '0;
        end else begin
          walk_one_bit(in_ch.code_bit, in_ch.last_bit);
        end
      end
    end
    pending <= letters_due.size();
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import hbd_pkg::*;

  localparam int LIMIT      = 500000;
  localparam int RAND_WORDS = 320;
  localparam int DRAIN      = 6;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic             cfg_wdata;
  int               pending;
  int               fail_count;
  int               cycles = 0;
  bit               steady = 1'b0;
  bit               written [NODE_COUNT_DEF];
  bit               claimed [NODE_COUNT_DEF];
  logic [IDX_W-1:0] known [$];

  hbd_in_if  in_ch ();
  hbd_out_if out_ch ();

  huffman_bit_decoder_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in        (in_ch),
    .out       (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  walk_checker u_walk_chk (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always #5 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [IDX_W-1:0] pick_known();
    return known[$urandom_range(0, known.size() - 1)];
  endfunction

  function automatic logic [IDX_W-1:0] fresh_index();
    int idx;
    do idx = $urandom_range(1, NODE_COUNT_DEF - 1); while (claimed[idx]);
    claimed[idx] = 1'b1;
    return IDX_W'(idx);
  endfunction

  // Stall the letter channel at random
  initial begin : letter_stall
    int n;
    forever begin
      n = steady ? 0 : gap_len();
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(input logic cmd, input logic [IDX_W-1:0] idx, l, r,
                           input logic leaf, input logic [LETTER_W-1:0] ltr,
                           input logic code, stop);
    int n;
    n = steady ? 0 : gap_len();
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    if (cmd == CMD_WRITE && !written[idx]) begin
      written[idx] = 1'b1;
      known.insert(known.size(), idx);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.node_addr   <= idx;
    in_ch.left_child  <= l;
    in_ch.right_child <= r;
    in_ch.is_leaf     <= leaf;
    in_ch.leaf_letter <= ltr;
    in_ch.code_bit    <= code;
    in_ch.last_bit    <= stop;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_node(input logic [IDX_W-1:0] idx, l, r, input logic leaf,
                            input logic [LETTER_W-1:0] ltr);
    send_word(CMD_WRITE, idx, l, r, leaf, ltr, 1'($urandom), 1'($urandom));
  endtask

  task automatic decode_bit(input logic code, stop);
    send_word(CMD_DECODE, 9'($urandom), 9'($urandom), 9'($urandom), 1'($urandom),
              8'($urandom), code, stop);
  endtask

  // Drop valid, wait for every predicted letter, then let the block go idle
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_loaded(input logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Grow a full tree from the root by splitting random leaves; write leaves
  // first and inner nodes children-first so no walk can hit an empty entry
  task automatic build_tree(input int leaves);
    logic [IDX_W-1:0] open_q [$];
    logic [IDX_W-1:0] inner_q [$];
    logic [IDX_W-1:0] lq [$];
    logic [IDX_W-1:0] rq [$];
    int               pick;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    claimed = '{default: 1'b0};
    claimed[0] = 1'b1;
    open_q.insert(0, '0);
    repeat (leaves - 1) begin
      pick = $urandom_range(0, open_q.size() - 1);
      inner_q.insert(inner_q.size(), open_q[pick]);
      open_q.delete(pick);
      a = fresh_index();
      b = fresh_index();
      lq.insert(lq.size(), a);
      rq.insert(rq.size(), b);
      open_q.insert(open_q.size(), a);
      open_q.insert(open_q.size(), b);
    end
    foreach (open_q[i])
      write_node(open_q[i], 9'($urandom), 9'($urandom), 1'b1, 8'($urandom));
    for (int i = inner_q.size() - 1; i >= 0; i--)
      write_node(inner_q[i], lq[i], rq[i], 1'b0, 8'($urandom));
  endtask

  // Mostly code bits, with rare stream ends and stray node writes
  task automatic stream_word();
    logic [IDX_W-1:0] idx;
    logic             leaf;
    if ($urandom_range(0, 99) < 6) begin
      idx  = ($urandom_range(0, 1) == 1) ? pick_known() : 9'($urandom);
      leaf = 1'($urandom);
      write_node(idx, leaf ? 9'($urandom) : pick_known(),
                 leaf ? 9'($urandom) : pick_known(), leaf, 8'($urandom));
    end else begin
      decode_bit(1'($urandom), $urandom_range(0, 99) < 8);
    end
  endtask

  initial begin : stimulus
    int count;
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_wdata         <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.command     <= CMD_WRITE;
    in_ch.node_addr   <= '0;
    in_ch.left_child  <= '0;
    in_ch.right_child <= '0;
    in_ch.is_leaf     <= 1'b0;
    in_ch.leaf_letter <= '0;
    in_ch.code_bit    <= 1'b0;
    in_ch.last_bit    <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // No tree loaded: decode words give nothing
    decode_bit(1'b0, 1'b0);
    decode_bit(1'b1, 1'b1);

    // Small tree: 0 -> (1 leaf 00, 2), 2 -> (511 leaf ff, 3), 3 is an empty inner node
    write_node(9'd511, 9'd511, 9'd511, 1'b1, 8'hff);
    write_node(9'd1, 9'd0, 9'd0, 1'b1, 8'h00);
    write_node(9'd3, 9'd0, 9'd0, 1'b0, 8'h00);
    write_node(9'd2, 9'd511, 9'd3, 1'b0, 8'hff);
    write_node(9'd0, 9'd1, 9'd2, 1'b0, 8'h00);
    settle();
    set_loaded(1'b1);
    decode_bit(1'b0, 1'b0);
    decode_bit(1'b1, 1'b0);
    decode_bit(1'b0, 1'b0);
    // Walk into the empty inner node and fall back to the root
    decode_bit(1'b1, 1'b0);
    decode_bit(1'b1, 1'b0);
    decode_bit(1'b0, 1'b0);
    decode_bit(1'b0, 1'b0);
    // Stream end in the middle of a code
    decode_bit(1'b1, 1'b1);
    decode_bit(1'b0, 1'b0);
    // Node write mid-walk returns to the root; root becomes a leaf
    decode_bit(1'b1, 1'b0);
    write_node(9'd0, 9'd0, 9'd511, 1'b1, 8'ha5);
    decode_bit(1'b0, 1'b0);
    decode_bit(1'b1, 1'b0);
    decode_bit(1'b1, 1'b1);
    settle();
    set_loaded(1'b0);
    decode_bit(1'b1, 1'b0);

    // Random trees and bit streams, one setting per phase
    count = 0;
    for (int phase = 0; count < RAND_WORDS; phase++) begin
      settle();
      steady = (phase % 4 == 3);
      set_loaded(phase % 5 != 4);
      build_tree((phase % 3 == 0) ? $urandom_range(1, 3) : $urandom_range(2, 12));
      repeat ($urandom_range(20, 60)) begin
        stream_word();
        count++;
      end
    end

    steady = 1'b0;
    settle();
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: files.f
hdl/hbd_pkg.sv
hdl/hbd_if.sv
hdl/hbd_ctrl.sv
hdl/hbd_datapath.sv
hdl/huffman_bit_decoder_core.sv
verif/walk_checker.sv
verif/tb_top.sv
